@@ rtl/tt_pkg.sv @@
`timescale 1ns / 1ps
package tt_pkg;
  localparam int CW       = 32;
  localparam int FRAC     = 14;
  localparam int NB       = 30;
  localparam int EW       = CW + 1;
  localparam int PW       = 2 * EW;
  localparam int SW       = PW + 1;
  localparam int MW       = SW - 1;
  localparam int SH_CELLS = $clog2(MW - NB + 1);
  localparam int SHK_W    = $clog2(SH_CELLS + 1);
  localparam int SQW      = 2 * NB + 1;
  localparam int RTW      = NB + 1;
  localparam int SQ_CELLS = NB + 1;
  localparam int SQK_W    = $clog2(NB + 1);
  localparam int QW       = FRAC + 1;
  localparam int DVK_W    = $clog2(FRAC + 1) + 1;
  localparam int NUMW     = NB + FRAC + 1;
  localparam int OW       = 16;
  localparam int QMAX     = 32767;

  typedef struct packed {
    logic [MW-1:0] mx;
    logic [MW-1:0] my;
    logic          nx;
    logic          ny;
    logic          wr;
  } sh_t;

  typedef struct packed {
    logic [SQW-1:0] n;
    logic [SQW-1:0] res;
    logic [NB-1:0]  ax;
    logic [NB-1:0]  ay;
    logic           nx;
    logic           ny;
    logic           wr;
  } sq_t;

  typedef struct packed {
    logic [NUMW-1:0] rx;
    logic [NUMW-1:0] ry;
    logic [QW-1:0]   qx;
    logic [QW-1:0]   qy;
    logic [RTW-1:0]  r;
    logic            nx;
    logic            ny;
    logic            wr;
  } dv_t;
endpackage

@@ rtl/tt_shift_cell.sv @@
`timescale 1ns / 1ps
module tt_shift_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [tt_pkg::SHK_W-1:0] k_i,
  input  logic                     in_v_i,
  output logic                     in_rdy_o,
  input  tt_pkg::sh_t              in_i,
  output logic                     out_v_o,
  input  logic                     out_rdy_i,
  output tt_pkg::sh_t              out_o
);
  import tt_pkg::*;

  logic          v_q;
  sh_t           d_q, d_d;
  logic [MW-1:0] orv;
  logic [7:0]    amt;
  logic          big;

  always_comb begin
    amt = 8'(1) << k_i;
    orv = in_i.mx | in_i.my;
    big = (orv >> (8'(NB - 1) + amt)) != '0;
    d_d = in_i;
    if (big) begin
      d_d.mx = in_i.mx >> amt;
      d_d.my = in_i.my >> amt;
    end
  end

  assign in_rdy_o = !v_q || out_rdy_i;
  assign out_v_o  = v_q;
  assign out_o    = d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_rdy_o) begin
      v_q <= in_v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_v_i && in_rdy_o) begin
      d_q <= d_d;
    end
  end
endmodule

@@ rtl/tt_sqrt_cell.sv @@
`timescale 1ns / 1ps
module tt_sqrt_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [tt_pkg::SQK_W-1:0] k_i,
  input  logic                     in_v_i,
  output logic                     in_rdy_o,
  input  tt_pkg::sq_t              in_i,
  output logic                     out_v_o,
  input  logic                     out_rdy_i,
  output tt_pkg::sq_t              out_o
);
  import tt_pkg::*;

  logic           v_q;
  sq_t            d_q, d_d;
  logic [SQW-1:0] bitv, t;

  always_comb begin
    bitv = SQW'(1) << {k_i, 1'b0};
    t    = in_i.res + bitv;
    d_d  = in_i;
    if (in_i.n >= t) begin
      d_d.n   = in_i.n - t;
      d_d.res = (in_i.res >> 1) + bitv;
    end else begin
      d_d.res = in_i.res >> 1;
    end
  end

  assign in_rdy_o = !v_q || out_rdy_i;
  assign out_v_o  = v_q;
  assign out_o    = d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_rdy_o) begin
      v_q <= in_v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_v_i && in_rdy_o) begin
      d_q <= d_d;
    end
  end
endmodule

@@ rtl/tt_div_cell.sv @@
`timescale 1ns / 1ps
module tt_div_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [tt_pkg::DVK_W-1:0] j_i,
  input  logic                     in_v_i,
  output logic                     in_rdy_o,
  input  tt_pkg::dv_t              in_i,
  output logic                     out_v_o,
  input  logic                     out_rdy_i,
  output tt_pkg::dv_t              out_o
);
  import tt_pkg::*;

  logic            v_q;
  dv_t             d_q, d_d;
  logic [NUMW-1:0] dv;

  always_comb begin
    dv  = NUMW'(in_i.r) << j_i;
    d_d = in_i;
    if (in_i.rx >= dv) begin
      d_d.rx = in_i.rx - dv;
      d_d.qx = in_i.qx | (QW'(1) << j_i);
    end
    if (in_i.ry >= dv) begin
      d_d.ry = in_i.ry - dv;
      d_d.qy = in_i.qy | (QW'(1) << j_i);
    end
  end

  assign in_rdy_o = !v_q || out_rdy_i;
  assign out_v_o  = v_q;
  assign out_o    = d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_rdy_o) begin
      v_q <= in_v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_v_i && in_rdy_o) begin
      d_q <= d_d;
    end
  end
endmodule

@@ rtl/triangle_tangent_2d.sv @@
// Stages: 3 front stages, 6 shift cells, 1 square stage, 31 square-root cells and
//   15 divide cells lie between an input transfer and its output transfer.
// Throughput: one triangle per cycle; every stage holds one item and moves it on
//   when the next stage is free, so bubbles collapse under output stall.
// Reset: rst_ni asynchronous, active low, clears all stage valid bits.
`timescale 1ns / 1ps
module triangle_tangent_2d (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, t0_u, t0_v, t1_u, t1_v, t2_u, t2_v
  input  logic [383:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // tangent_x, tangent_y
  output logic [31:0]  m_axis_tdata_o,
  // written
  output logic [0:0]   m_axis_tuser_o
);
  import tt_pkg::*;

  logic signed [EW-1:0] sx[12];
  logic signed [EW-1:0] e_d[8], e_q[8];
  logic signed [PW-1:0] p_d[6], p_q[6];
  logic signed [SW-1:0] c_d[3], c_q[3];
  logic [2:0]           v_q, rdy;

  always_comb begin
    for (int i = 0; i < 12; i++) begin
      sx[i] = EW'($signed(s_axis_tdata_i[32*i +: CW]));
    end
    e_d[0] = sx[2] - sx[0];
    e_d[1] = sx[3] - sx[1];
    e_d[2] = sx[4] - sx[0];
    e_d[3] = sx[5] - sx[1];
    e_d[4] = sx[8] - sx[6];
    e_d[5] = sx[9] - sx[7];
    e_d[6] = sx[10] - sx[6];
    e_d[7] = sx[11] - sx[7];
    p_d[0] = PW'(e_q[5]) * PW'(e_q[6]);
    p_d[1] = PW'(e_q[4]) * PW'(e_q[7]);
    p_d[2] = PW'(e_q[0]) * PW'(e_q[7]);
    p_d[3] = PW'(e_q[2]) * PW'(e_q[5]);
    p_d[4] = PW'(e_q[1]) * PW'(e_q[7]);
    p_d[5] = PW'(e_q[3]) * PW'(e_q[5]);
    c_d[0] = SW'(p_q[0]) - SW'(p_q[1]);
    c_d[1] = SW'(p_q[3]) - SW'(p_q[2]);
    c_d[2] = SW'(p_q[5]) - SW'(p_q[4]);
  end

  sh_t  sh_w[SH_CELLS+1];
  logic shv[SH_CELLS+1];
  logic shr[SH_CELLS+1];

  assign rdy[0] = !v_q[0] || rdy[1];
  assign rdy[1] = !v_q[1] || rdy[2];
  assign rdy[2] = !v_q[2] || shr[0];
  assign s_axis_tready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= s_axis_tvalid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && rdy[0]) e_q <= e_d;
    if (v_q[0] && rdy[1]) p_q <= p_d;
    if (v_q[1] && rdy[2]) c_q <= c_d;
  end

  always_comb begin
    sh_w[0].nx = c_q[1][SW-1] ^ c_q[0][SW-1];
    sh_w[0].ny = c_q[2][SW-1] ^ c_q[0][SW-1];
    sh_w[0].mx = c_q[1][SW-1] ? MW'(-c_q[1]) : MW'(c_q[1]);
    sh_w[0].my = c_q[2][SW-1] ? MW'(-c_q[2]) : MW'(c_q[2]);
    sh_w[0].wr = (c_q[0] != '0) && ((c_q[1] != '0) || (c_q[2] != '0));
  end
  assign shv[0] = v_q[2];

  for (genvar g = 0; g < SH_CELLS; g++) begin : g_sh
    tt_shift_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .k_i       (SHK_W'(SH_CELLS - 1 - g)),
      .in_v_i    (shv[g]),
      .in_rdy_o  (shr[g]),
      .in_i      (sh_w[g]),
      .out_v_o   (shv[g+1]),
      .out_rdy_i (shr[g+1]),
      .out_o     (sh_w[g+1])
    );
  end

  logic            sqs_v_q, sqs_rdy;
  logic [2*NB-1:0] ax2_q, ay2_q;
  logic [NB-1:0]   ax_q, ay_q;
  logic            snx_q, sny_q, swr_q;
  sq_t             sq_w[SQ_CELLS+1];
  logic            sqv[SQ_CELLS+1];
  logic            sqr[SQ_CELLS+1];

  assign sqs_rdy        = !sqs_v_q || sqr[0];
  assign shr[SH_CELLS]  = sqs_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sqs_v_q <= 1'b0;
    end else if (sqs_rdy) begin
      sqs_v_q <= shv[SH_CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (shv[SH_CELLS] && sqs_rdy) begin
      ax_q  <= sh_w[SH_CELLS].mx[NB-1:0];
      ay_q  <= sh_w[SH_CELLS].my[NB-1:0];
      ax2_q <= (2*NB)'(sh_w[SH_CELLS].mx[NB-1:0]) * (2*NB)'(sh_w[SH_CELLS].mx[NB-1:0]);
      ay2_q <= (2*NB)'(sh_w[SH_CELLS].my[NB-1:0]) * (2*NB)'(sh_w[SH_CELLS].my[NB-1:0]);
      snx_q <= sh_w[SH_CELLS].nx;
      sny_q <= sh_w[SH_CELLS].ny;
      swr_q <= sh_w[SH_CELLS].wr;
    end
  end

  always_comb begin
    sq_w[0].n   = SQW'(ax2_q) + SQW'(ay2_q);
    sq_w[0].res = '0;
    sq_w[0].ax  = ax_q;
    sq_w[0].ay  = ay_q;
    sq_w[0].nx  = snx_q;
    sq_w[0].ny  = sny_q;
    sq_w[0].wr  = swr_q;
  end
  assign sqv[0] = sqs_v_q;

  for (genvar g = 0; g < SQ_CELLS; g++) begin : g_sq
    tt_sqrt_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .k_i       (SQK_W'(NB - g)),
      .in_v_i    (sqv[g]),
      .in_rdy_o  (sqr[g]),
      .in_i      (sq_w[g]),
      .out_v_o   (sqv[g+1]),
      .out_rdy_i (sqr[g+1]),
      .out_o     (sq_w[g+1])
    );
  end

  dv_t            dv_w[QW+1];
  logic           dvv[QW+1];
  logic           dvr[QW+1];
  logic [RTW-1:0] root;

  assign root = sq_w[SQ_CELLS].res[RTW-1:0];

  always_comb begin
    dv_w[0].r  = root;
    dv_w[0].rx = NUMW'({sq_w[SQ_CELLS].ax, FRAC'(0)}) + NUMW'(root >> 1);
    dv_w[0].ry = NUMW'({sq_w[SQ_CELLS].ay, FRAC'(0)}) + NUMW'(root >> 1);
    dv_w[0].qx = '0;
    dv_w[0].qy = '0;
    dv_w[0].nx = sq_w[SQ_CELLS].nx;
    dv_w[0].ny = sq_w[SQ_CELLS].ny;
    dv_w[0].wr = sq_w[SQ_CELLS].wr && (root != '0);
  end
  assign dvv[0]        = sqv[SQ_CELLS];
  assign sqr[SQ_CELLS] = dvr[0];

  for (genvar g = 0; g < QW; g++) begin : g_dv
    tt_div_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .j_i       (DVK_W'(FRAC - g)),
      .in_v_i    (dvv[g]),
      .in_rdy_o  (dvr[g]),
      .in_i      (dv_w[g]),
      .out_v_o   (dvv[g+1]),
      .out_rdy_i (dvr[g+1]),
      .out_o     (dv_w[g+1])
    );
  end

  logic [31:0]   qx32, qy32;
  logic [OW-1:0] cx, cy, tgx, tgy;

  always_comb begin
    qx32 = 32'(dv_w[QW].qx);
    qy32 = 32'(dv_w[QW].qy);
    cx   = (qx32 > 32'(QMAX)) ? OW'(QMAX) : qx32[OW-1:0];
    cy   = (qy32 > 32'(QMAX)) ? OW'(QMAX) : qy32[OW-1:0];
    tgx  = '0;
    tgy  = '0;
    if (dv_w[QW].wr) begin
      tgx = dv_w[QW].nx ? OW'(-cx) : cx;
      tgy = dv_w[QW].ny ? OW'(-cy) : cy;
    end
  end

  assign dvr[QW]         = m_axis_tready_i;
  assign m_axis_tvalid_o = dvv[QW];
  assign m_axis_tdata_o  = {tgy, tgx};
  assign m_axis_tuser_o  = dv_w[QW].wr;

  a_zero_when_unwritten: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o == 32'd0)
    else $error("unwritten result carries a nonzero tangent");

  a_nonzero_when_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o != 32'd0)
    else $error("written result carries a zero tangent");

  a_stall_from_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled while the output side is free");
endmodule
